// ----- rtl/srsw_pkg.sv -----
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and constants for the selective-repeat sender window.
// ----------------------------------------------------------------------------
`default_nettype none

package srsw_pkg;

  localparam int WINDOW       = 8;
  localparam int PACKET_BYTES = 1024;
  localparam int SLOT_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int PKT_W        = 16;
  localparam int OFF_W        = 32;

  typedef enum logic [1:0] {
    ST_UNSENT = 2'd0,
    ST_SENT   = 2'd1,
    ST_ACKED  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctl_t;

  typedef struct packed {
    logic              shift;
    status_t           tail;
    logic [WINDOW-1:0] wr;
  } row_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/srsw_cell.sv -----
// ----------------------------------------------------------------------------
// srsw_cell
// One window slot: holds its status, is marked acked on a write, else takes its neighbor's on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire srsw_pkg::cell_ctl_t ctl,
  input  wire srsw_pkg::status_t  nb_in,
  output srsw_pkg::status_t       st
);
  import srsw_pkg::*;

  status_t st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_UNSENT;
    end else if (ctl.wr) begin
      st_r <= ST_ACKED;
    end else if (ctl.shift) begin
      st_r <= nb_in;
    end
  end

  assign st = st_r;

endmodule

`default_nettype wire

// ----- rtl/srsw_row.sv -----
// ----------------------------------------------------------------------------
// srsw_row
// Chain of slot cells; slot 0 is the head, the tail is fed from outside.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_row (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire srsw_pkg::row_ctl_t                         ctl,
  output srsw_pkg::status_t [srsw_pkg::WINDOW-1:0]        st
);
  import srsw_pkg::*;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    cell_ctl_t cctl;
    status_t   nb;

    assign cctl.shift = ctl.shift;
    assign cctl.wr    = ctl.wr[i];

    if (i == WINDOW - 1) begin : g_tail
      assign nb = ctl.tail;
    end else begin : g_mid
      assign nb = st[i+1];
    end

    srsw_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (cctl),
      .nb_in (nb),
      .st    (st[i])
    );
  end

endmodule

`default_nettype wire

// ----- rtl/selective_repeat_sender_window.sv -----
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender window of a selective-repeat transfer: send, ack and timeout events.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A send or
// timeout event walks the slot chain once, one slot per cycle, and then
// flushes its last command; it gives one result per command or a single
// empty result. An ack goes straight to its report, or first slides the
// window past the leading acked slots when the window slides. Unused
// opcodes go straight to the report. The closing result shows in the
// first cycle that busy is low, when the next transaction can already be
// taken. Results come out at most one per cycle on out_valid and cannot
// be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_sender_window (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [15:0] in_ack_packet,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  output logic             out_valid,
  output logic             out_send_valid,
  output logic [15:0]      out_packet_index,
  output logic [31:0]      out_byte_offset,
  output logic             out_relay_sel,
  output logic             out_final_packet,
  output logic             out_retransmit,
  output logic             out_ack_rejected,
  output logic             out_transfer_done,
  output logic             out_run_last
);
  import srsw_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_FLUSH  = 5'b00100,
    S_SLIDE  = 5'b01000,
    S_REPORT = 5'b10000
  } fsm_t;

  fsm_t state_r, state_nxt;

  logic [SLOT_W-1:0] s_r, s_nxt;
  logic              retx_r, retx_nxt;
  logic [PKT_W-1:0]  base_r, base_nxt;
  logic [PKT_W-1:0]  num_r;
  logic              pend_vld_r, pend_vld_nxt;
  logic [PKT_W-1:0]  pend_pkt_r, pend_pkt_nxt;
  logic              pend_retx_r, pend_retx_nxt;
  logic              done_r, done_nxt;
  logic              rej_r, rej_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_send_r, out_send_nxt;
  logic [PKT_W-1:0]  out_pkt_r, out_pkt_nxt;
  logic [OFF_W-1:0]  out_off_r, out_off_nxt;
  logic              out_odd_r, out_odd_nxt;
  logic              out_fin_r, out_fin_nxt;
  logic              out_retx_r, out_retx_nxt;
  logic              out_rej_r, out_rej_nxt;
  logic              out_done_r, out_done_nxt;
  logic              out_last_r, out_last_nxt;

  status_t [WINDOW-1:0] st;
  row_ctl_t             row_ctl;

  logic [WINDOW-1:0] in_rng;
  logic [WINDOW-1:0] acked;
  logic              near_end;
  logic              done_now;
  logic              hit;
  logic [PKT_W-1:0]  diff;
  logic              ack_rej;
  logic              ack_slide;

  srsw_row u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (row_ctl),
    .st    (st)
  );

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      in_rng[i] = ({1'b0, base_r} + 17'(i)) < {1'b0, num_r};
      acked[i]  = (st[i] == ST_ACKED);
    end
  end

  assign near_end = ({1'b0, base_r} + 17'(WINDOW)) >= {1'b0, num_r};
  assign done_now = near_end && (&(~in_rng | acked));

  assign hit = in_rng[s_r] && (retx_r ? (st[0] == ST_SENT) : (st[0] == ST_UNSENT));

  assign diff    = in_ack_packet - base_r;
  assign ack_rej = (in_ack_packet < base_r) || (diff >= PKT_W'(WINDOW)) ||
                   (in_ack_packet >= num_r);
  assign ack_slide = !ack_rej && (in_ack_packet == base_r) &&
                     (({1'b0, in_ack_packet} + 17'(WINDOW)) < {1'b0, num_r});

  always_comb begin
    state_nxt     = state_r;
    s_nxt         = s_r;
    retx_nxt      = retx_r;
    base_nxt      = base_r;
    pend_vld_nxt  = pend_vld_r;
    pend_pkt_nxt  = pend_pkt_r;
    pend_retx_nxt = pend_retx_r;
    done_nxt      = done_r;
    rej_nxt       = rej_r;
    row_ctl.shift = 1'b0;
    row_ctl.tail  = ST_UNSENT;
    row_ctl.wr    = '0;

    out_valid_nxt = 1'b0;
    out_send_nxt  = 1'b0;
    out_pkt_nxt   = '0;
    out_off_nxt   = '0;
    out_odd_nxt   = 1'b0;
    out_fin_nxt   = 1'b0;
    out_retx_nxt  = 1'b0;
    out_rej_nxt   = 1'b0;
    out_done_nxt  = done_r;
    out_last_nxt  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          rej_nxt = 1'b0;
          unique case (in_opcode) inside
            OP_SEND, OP_TIMEOUT: begin
              s_nxt        = '0;
              retx_nxt     = (in_opcode == OP_TIMEOUT);
              pend_vld_nxt = 1'b0;
              done_nxt     = done_now;
              state_nxt    = S_SCAN;
            end
            OP_ACK: begin
              rej_nxt = ack_rej;
              if (!ack_rej) begin
                row_ctl.wr = WINDOW'(1) << diff[SLOT_W-1:0];
              end
              state_nxt = ack_slide ? S_SLIDE : S_REPORT;
            end
            default: begin
              state_nxt = S_REPORT;
            end
          endcase
        end
      end
      S_SCAN: begin
        row_ctl.shift = 1'b1;
        row_ctl.tail  = (hit && !retx_r) ? ST_SENT : st[0];
        if (hit) begin
          if (pend_vld_r) begin
            out_valid_nxt = 1'b1;
            out_send_nxt  = 1'b1;
            out_pkt_nxt   = pend_pkt_r;
            out_off_nxt   = OFF_W'(pend_pkt_r) * OFF_W'(PACKET_BYTES);
            out_odd_nxt   = pend_pkt_r[0];
            out_fin_nxt   = ({1'b0, pend_pkt_r} + 17'd1) == {1'b0, num_r};
            out_retx_nxt  = pend_retx_r;
          end
          pend_vld_nxt  = 1'b1;
          pend_pkt_nxt  = base_r + PKT_W'(s_r);
          pend_retx_nxt = retx_r;
        end
        if (s_r == SLOT_W'(WINDOW - 1)) begin
          state_nxt = S_FLUSH;
        end else begin
          s_nxt = s_r + SLOT_W'(1);
        end
      end
      S_FLUSH: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        if (pend_vld_r) begin
          out_send_nxt = 1'b1;
          out_pkt_nxt  = pend_pkt_r;
          out_off_nxt  = OFF_W'(pend_pkt_r) * OFF_W'(PACKET_BYTES);
          out_odd_nxt  = pend_pkt_r[0];
          out_fin_nxt  = ({1'b0, pend_pkt_r} + 17'd1) == {1'b0, num_r};
          out_retx_nxt = pend_retx_r;
        end
        state_nxt = S_IDLE;
      end
      S_SLIDE: begin
        if (st[0] == ST_ACKED) begin
          row_ctl.shift = 1'b1;
          row_ctl.tail  = ST_UNSENT;
          base_nxt      = base_r + PKT_W'(1);
        end else begin
          state_nxt = S_REPORT;
        end
      end
      S_REPORT: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        out_rej_nxt   = rej_r;
        out_done_nxt  = done_now;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      num_r       <= PKT_W'(1);
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        num_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    s_r         <= s_nxt;
    retx_r      <= retx_nxt;
    pend_pkt_r  <= pend_pkt_nxt;
    pend_retx_r <= pend_retx_nxt;
    done_r      <= done_nxt;
    rej_r       <= rej_nxt;
    out_send_r  <= out_send_nxt;
    out_pkt_r   <= out_pkt_nxt;
    out_off_r   <= out_off_nxt;
    out_odd_r   <= out_odd_nxt;
    out_fin_r   <= out_fin_nxt;
    out_retx_r  <= out_retx_nxt;
    out_rej_r   <= out_rej_nxt;
    out_done_r  <= out_done_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_send_valid    = out_send_r;
  assign out_packet_index  = out_pkt_r;
  assign out_byte_offset   = out_off_r;
  assign out_relay_sel     = out_odd_r;
  assign out_final_packet  = out_fin_r;
  assign out_retransmit    = out_retx_r;
  assign out_ack_rejected  = out_rej_r;
  assign out_transfer_done = out_done_r;
  assign out_run_last      = out_last_r;

`ifndef SYNTH
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && out_run_last)
    else $error("transaction ended without a closing result");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_last |-> !busy)
    else $error("closing result while still busy");

  a_rej_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ack_rejected |-> !out_send_valid && out_run_last)
    else $error("rejected ack paired with a transmit command");
`endif

endmodule

`default_nettype wire

// ----- tb/srsw_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// srsw_tb_pkg
// Result record and scoreboard for the selective-repeat sender window bench.
// The scoreboard keeps its own copy of the slot states, window base and
// packet count, works out the commands each accepted transaction must cause
// and checks every result against them in order.
// ----------------------------------------------------------------------------
package srsw_tb_pkg;
  import srsw_pkg::*;

  typedef struct packed {
    logic        send_valid;
    logic [15:0] packet_index;
    logic [31:0] byte_offset;
    logic        relay_sel;
    logic        final_packet;
    logic        retransmit;
    logic        ack_rejected;
    logic        transfer_done;
    logic        run_last;
  } tx_result_t;

  class send_window_scoreboard;
    status_t     slot_st[WINDOW];
    int unsigned base;
    int unsigned npkts;
    tx_result_t  expected_cmds[$];
    int          errors;

    function new();
      foreach (slot_st[s]) slot_st[s] = ST_UNSENT;
      base   = 0;
      npkts  = 1;
      errors = 0;
    endfunction

    function void set_num_packets(logic [15:0] value);
      npkts = {16'd0, value};
    endfunction

    function void note_event(opcode_t op, logic [15:0] ack_pkt);
      int unsigned cmd_pkts[$];
      int unsigned a;
      int unsigned lead;
      int unsigned p;
      int          s;
      bit          rej;
      bit          done;
      tx_result_t  r;
      a   = {16'd0, ack_pkt};
      rej = 0;
      case (op) inside
        OP_SEND, OP_TIMEOUT: begin
          for (s = 0; s < WINDOW; s++) begin
            if (base + s < npkts) begin
              if (op == OP_SEND && slot_st[s] == ST_UNSENT) begin
                cmd_pkts.push_back(base + s);
                slot_st[s] = ST_SENT;
              end else if (op == OP_TIMEOUT && slot_st[s] == ST_SENT) begin
                cmd_pkts.push_back(base + s);
              end
            end
          end
        end
        OP_ACK: begin
          if (a < base || a - base >= WINDOW || a >= npkts) begin
            rej = 1;
          end else begin
            slot_st[a - base] = ST_ACKED;
            // slide past the leading acked slots, fresh slots come in unsent
            if (npkts > WINDOW && a < npkts - WINDOW && a == base) begin
              lead = 0;
              while (lead < WINDOW && slot_st[lead] == ST_ACKED) lead++;
              for (s = 0; s < WINDOW; s++) begin
                slot_st[s] = (s + lead < WINDOW) ? slot_st[s + lead] : ST_UNSENT;
              end
              base = (base + lead) & 32'hFFFF;
            end
          end
        end
        default: ;
      endcase

      done = 1;
      if (int'(base) < int'(npkts) - WINDOW) done = 0;
      for (s = 0; s < WINDOW; s++) begin
        if (base + s < npkts && slot_st[s] != ST_ACKED) done = 0;
      end

      if (cmd_pkts.size() == 0) begin
        r               = '0;
        r.ack_rejected  = rej;
        r.transfer_done = done;
        r.run_last      = 1'b1;
        expected_cmds.push_back(r);
      end else begin
        foreach (cmd_pkts[k]) begin
          p               = cmd_pkts[k];
          r               = '0;
          r.send_valid    = 1'b1;
          r.packet_index  = p[15:0];
          r.byte_offset   = p * PACKET_BYTES;
          r.relay_sel     = p[0];
          r.final_packet  = (p + 1 == npkts);
          r.retransmit    = (op == OP_TIMEOUT);
          r.transfer_done = done;
          r.run_last      = (k == cmd_pkts.size() - 1);
          expected_cmds.push_back(r);
        end
      end
    endfunction

    function void compare_field(string fname, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, fname, want, got);
        errors++;
      end
    endfunction

    function void check_result(tx_result_t got);
      tx_result_t want;
      if (expected_cmds.size() == 0) begin
        $display("%0t: result with no transaction pending, expected none, actual 0x%0h",
                 $time, got);
        errors++;
        return;
      end
      want = expected_cmds.pop_front();
      compare_field("send_valid", 32'(want.send_valid), 32'(got.send_valid));
      compare_field("packet_index", 32'(want.packet_index), 32'(got.packet_index));
      compare_field("byte_offset", want.byte_offset, got.byte_offset);
      compare_field("relay_sel", 32'(want.relay_sel), 32'(got.relay_sel));
      compare_field("final_packet", 32'(want.final_packet), 32'(got.final_packet));
      compare_field("retransmit", 32'(want.retransmit), 32'(got.retransmit));
      compare_field("ack_rejected", 32'(want.ack_rejected), 32'(got.ack_rejected));
      compare_field("transfer_done", 32'(want.transfer_done), 32'(got.transfer_done));
      compare_field("run_last", 32'(want.run_last), 32'(got.run_last));
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Bench for the selective-repeat sender window controller.
// A directed run walks sends, timeouts, in-order, out-of-order, repeated,
// early and out-of-window acks and the unused opcode; random traffic then
// runs mostly well-formed transfers under several packet counts, with
// bursty start timing, and every result is checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srsw_pkg::*;
  import srsw_tb_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_opcode;
  logic [15:0] in_ack_packet;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        out_valid;
  logic        out_send_valid;
  logic [15:0] out_packet_index;
  logic [31:0] out_byte_offset;
  logic        out_relay_sel;
  logic        out_final_packet;
  logic        out_retransmit;
  logic        out_ack_rejected;
  logic        out_transfer_done;
  logic        out_run_last;

  tx_result_t            seen_result;
  send_window_scoreboard sb = new();
  int                    burst_left;

  selective_repeat_sender_window DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_ack_packet     (in_ack_packet),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_send_valid    (out_send_valid),
    .out_packet_index  (out_packet_index),
    .out_byte_offset   (out_byte_offset),
    .out_relay_sel     (out_relay_sel),
    .out_final_packet  (out_final_packet),
    .out_retransmit    (out_retransmit),
    .out_ack_rejected  (out_ack_rejected),
    .out_transfer_done (out_transfer_done),
    .out_run_last      (out_run_last)
  );

  assign seen_result = {out_send_valid, out_packet_index, out_byte_offset, out_relay_sel,
                        out_final_packet, out_retransmit, out_ack_rejected,
                        out_transfer_done, out_run_last};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // results first, then the transaction taken at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(seen_result);
      if (start && !busy) sb.note_event(opcode_t'(in_opcode), in_ack_packet);
    end
  end

  task automatic drive_event(opcode_t op, logic [15:0] ack_pkt);
    start         <= 1'b1;
    in_opcode     <= op;
    in_ack_packet <= ack_pkt;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // wait for every expected result, then let a slide finish
  task automatic drain();
    start <= 1'b0;
    while (sb.expected_cmds.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_num_packets(logic [15:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_num_packets(value);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [15:0] capped(int unsigned value);
    return (value > 65535) ? 16'hFFFF : value[15:0];
  endfunction

  task automatic run_traffic(int n_items);
    int          r;
    int          gap;
    opcode_t     op;
    logic [15:0] ack_pkt;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        drain();
      end else if (burst_left == 0) begin
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        burst_left = $urandom_range(1, 24);
        if (gap != 0) pause_cycles(gap);
      end
      if (burst_left != 0) burst_left--;

      r       = $urandom_range(0, 99);
      ack_pkt = 16'($urandom_range(0, 65535));
      if (r < 28) begin
        op = OP_SEND;
      end else if (r < 38) begin
        op = OP_TIMEOUT;
      end else if (r < 42) begin
        op = OP_NONE;
      end else if (r < 50) begin
        op = OP_ACK;
        case ($urandom_range(0, 3))
          0: ack_pkt = 16'(sb.base - 1);
          1: ack_pkt = 16'(sb.base + WINDOW);
          2: ack_pkt = 16'(sb.npkts);
          default: ;
        endcase
      end else begin
        op = OP_ACK;
        if ($urandom_range(0, 1) == 0) ack_pkt = 16'(sb.base);
        else ack_pkt = 16'(sb.base + $urandom_range(0, WINDOW - 1));
      end
      drive_event(op, ack_pkt);
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_opcode     <= OP_SEND;
    in_ack_packet <= '0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    burst_left    = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // single packet transfer at the reset packet count
    drive_event(OP_SEND, 16'h0000);
    drive_event(OP_TIMEOUT, 16'hFFFF);
    drive_event(OP_ACK, 16'h0001);
    drive_event(OP_ACK, 16'h0000);
    drive_event(OP_NONE, 16'hFFFF);
    drive_event(OP_SEND, 16'h0000);

    // window slides, out-of-order, repeated, early and rejected acks
    write_num_packets(16'd20);
    drive_event(OP_SEND, 16'h0000);
    drive_event(OP_ACK, 16'd0);
    drive_event(OP_TIMEOUT, 16'h0000);
    drive_event(OP_SEND, 16'h0000);
    drive_event(OP_ACK, 16'd3);
    drive_event(OP_ACK, 16'd5);
    drive_event(OP_ACK, 16'd1);
    drive_event(OP_ACK, 16'd2);
    drive_event(OP_ACK, 16'd1);
    drive_event(OP_ACK, 16'd12);
    drive_event(OP_ACK, 16'hFFFF);
    drive_event(OP_ACK, 16'd11);
    drive_event(OP_SEND, 16'h0000);
    drive_event(OP_ACK, 16'd11);
    drive_event(OP_TIMEOUT, 16'h0000);
    drive_event(OP_NONE, 16'h0000);
    drive_event(OP_ACK, 16'd4);

    write_num_packets(16'd40);
    run_traffic(70);
    write_num_packets(16'd0);
    run_traffic(8);
    write_num_packets(16'd1);
    run_traffic(8);
    write_num_packets(16'hFFFF);
    run_traffic(90);
    write_num_packets(capped(sb.base + $urandom_range(9, 60)));
    run_traffic(70);
    write_num_packets(capped(sb.base + $urandom_range(1, WINDOW)));
    run_traffic(40);
    write_num_packets(16'($urandom_range(1, 65535)));
    run_traffic(40);
    write_num_packets(capped(sb.base + 200));
    run_traffic(90);

    drain();
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
